### src/hpd_pkg.sv
// package for the heap process dispatcher
// holds item structs, sizes, the key width and op codes; no dependencies
package hpd_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 49;

  typedef struct packed {
    logic        operation;
    logic [15:0] priority_req;
    logic [31:0] required_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] dispatched_priority;
    logic [31:0] dispatched_elapsed;
    logic [31:0] dispatched_required;
    logic        finished;
    logic [31:0] switch_total;
    logic        queue_empty;
    logic        queue_full;
    logic [8:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [15:0] prio;
    logic [31:0] elapsed;
    logic [31:0] required;
  } entry_t;

  localparam logic OpInsert   = 1'b0;
  localparam logic OpDispatch = 1'b1;

endpackage

### src/heap_process_dispatcher.sv
// heap process dispatcher top level
// depends on hpd_pkg; holds the heap memory, the sequencer and the key multiplier
//
// One item at a time: busy is high from acceptance through the result strobe.
// The heap sits in a single-port memory with registered reads. Each heap level
// walked by a sift takes reads, one 16x33 key multiply per operand through one
// shared multiplier, a compare and writes. An insert writes the new entry at the
// end of the heap and climbs; a dispatch reads the root and, when more entries
// are held, the last one, then descends. A process that is not finished goes
// back in and climbs like an insert. A full heap holds 256 entries. The result
// shows on result_o with done_o high for one cycle and cannot be stalled. No
// clearing pass is needed after reset.
module heap_process_dispatcher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hpd_pkg::in_item_t item_i,
  output logic              done_o,
  output hpd_pkg::out_item_t result_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_INS_WR, S_UP_CHK, S_UP_RDP, S_UP_WTP, S_UP_CMP, S_UP_WR2,
    S_DQ_RD0, S_DQ_WT0, S_DQ_RDL, S_DQ_WTL, S_DQ_WR0,
    S_DN_CHK, S_DN_RDL, S_DN_WTL, S_DN_KL, S_DN_RDR, S_DN_WTR, S_DN_KR,
    S_DN_WR1, S_REINS, S_DONE
  } state_e;

  localparam int unsigned IdxW = hpd_pkg::IdxW;
  localparam int unsigned CntW = hpd_pkg::CntW;
  localparam int unsigned KeyW = hpd_pkg::KeyW;

  // heap memory, one port, registered read
  hpd_pkg::entry_t mem [hpd_pkg::Capacity];
  logic            mem_we;
  logic [IdxW-1:0] mem_addr;
  hpd_pkg::entry_t mem_wdata;
  hpd_pkg::entry_t mem_rdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  state_e             state_q;
  logic [CntW-1:0]    count_q;
  logic [31:0]        sw_q;
  logic [CntW-1:0]    pos_q, pick_q;
  hpd_pkg::entry_t    cur_q;      // moving entry
  logic [KeyW-1:0]    ckey_q;     // key of moving entry
  hpd_pkg::entry_t    pent_q;     // picked child / parent entry
  logic [KeyW-1:0]    pkey_q;
  hpd_pkg::entry_t    top_q;
  hpd_pkg::out_item_t res_q;
  logic               done_q;

  // shared key multiplier: prio * (elapsed + 1)
  hpd_pkg::entry_t mul_src;
  logic [KeyW-1:0] mul_key;
  assign mul_key = KeyW'(mul_src.prio) * (KeyW'(mul_src.elapsed) + KeyW'(1));

  always_comb begin
    mul_src = mem_rdata;
    if (state_q == S_INS_WR || state_q == S_DQ_WR0) mul_src = cur_q;
  end

  logic [CntW-1:0] parent_idx;
  assign parent_idx = (pos_q - CntW'(1)) >> 1;
  logic [CntW:0]   lc_w;
  assign lc_w = {pos_q, 1'b1};

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pos_q[IdxW-1:0];
    mem_wdata = cur_q;
    case (state_q)
      S_INS_WR: begin mem_we = 1'b1; mem_addr = pos_q[IdxW-1:0]; end
      S_UP_RDP: mem_addr = parent_idx[IdxW-1:0];
      S_UP_WR2: begin
        mem_we = 1'b1; mem_addr = pos_q[IdxW-1:0]; mem_wdata = pent_q;
      end
      S_DQ_RD0: mem_addr = '0;
      S_DQ_RDL: mem_addr = count_q[IdxW-1:0];
      S_DQ_WR0: begin mem_we = 1'b1; mem_addr = '0; end
      S_DN_RDL: mem_addr = lc_w[IdxW-1:0];
      S_DN_RDR: mem_addr = IdxW'(lc_w + 1'b1);
      S_DN_WR1: begin
        mem_we = 1'b1; mem_addr = pos_q[IdxW-1:0]; mem_wdata = pent_q;
      end
      S_REINS:  begin mem_we = 1'b1; mem_addr = pos_q[IdxW-1:0]; end
      default: ;
    endcase
  end

  logic [32:0] next_el;
  assign next_el = {1'b0, top_q.elapsed} + 33'(top_q.prio);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      sw_q    <= '0;
      done_q  <= 1'b0;
      pos_q <= '0; pick_q <= '0;
      cur_q <= '0; ckey_q <= '0; pent_q <= '0; pkey_q <= '0; top_q <= '0;
      res_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: if (start) begin
          if (item_i.operation == hpd_pkg::OpInsert) begin
            cur_q <= '{prio: item_i.priority_req, elapsed: '0,
                       required: item_i.required_time};
            if (count_q >= CntW'(hpd_pkg::Capacity)) begin
              res_q   <= '{queue_full: 1'b1, default: '0};
              state_q <= S_DONE;
            end else begin
              res_q   <= '0;
              pos_q   <= count_q;
              state_q <= S_INS_WR;
            end
          end else if (count_q == '0) begin
            res_q   <= '{queue_empty: 1'b1, default: '0};
            state_q <= S_DONE;
          end else begin
            res_q   <= '0;
            if (sw_q != '1) sw_q <= sw_q + 32'd1;
            count_q <= count_q - CntW'(1);
            state_q <= S_DQ_RD0;
          end
        end
        // write new entry at pos and start climbing
        S_INS_WR: begin
          ckey_q  <= mul_key;
          count_q <= count_q + CntW'(1);
          state_q <= S_UP_CHK;
        end
        S_UP_CHK: state_q <= (pos_q == '0) ? S_DONE : S_UP_RDP;
        S_UP_RDP: state_q <= S_UP_WTP;
        S_UP_WTP: begin
          pent_q  <= mem_rdata;
          pkey_q  <= mul_key;
          state_q <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (ckey_q >= pkey_q) state_q <= S_DONE;
          else state_q <= S_UP_WR2;
        end
        // parent moves down, moving entry goes up a level
        S_UP_WR2: begin
          pos_q   <= parent_idx;
          state_q <= S_REINS;
        end
        S_REINS: state_q <= S_UP_CHK;
        // dispatch: fetch root, then last entry if the heap held more than one
        S_DQ_RD0: state_q <= S_DQ_WT0;
        S_DQ_WT0: begin
          top_q <= mem_rdata;
          res_q <= '{dispatched_priority: mem_rdata.prio,
                     dispatched_elapsed: mem_rdata.elapsed,
                     dispatched_required: mem_rdata.required,
                     default: '0};
          state_q <= (count_q == '0) ? S_DN_CHK : S_DQ_RDL;
          pos_q   <= '0;
          if (count_q == '0) pick_q <= '0;
        end
        S_DQ_RDL: state_q <= S_DQ_WTL;
        S_DQ_WTL: begin
          cur_q   <= mem_rdata;
          ckey_q  <= mul_key;
          state_q <= S_DQ_WR0;
        end
        S_DQ_WR0: state_q <= S_DN_CHK;
        S_DN_CHK: begin
          if (count_q == '0 || lc_w >= {1'b0, count_q}) state_q <= S_DN_WR1;
          else state_q <= S_DN_RDL;
          pick_q <= pos_q;
          pent_q <= cur_q;
          pkey_q <= ckey_q;
        end
        S_DN_RDL: state_q <= S_DN_WTL;
        S_DN_WTL: begin
          if (ckey_q >= mul_key) begin
            pick_q <= lc_w[CntW-1:0];
            pent_q <= mem_rdata;
            pkey_q <= mul_key;
          end
          state_q <= S_DN_KL;
        end
        S_DN_KL: state_q <= ((lc_w + 1'b1) < {1'b0, count_q}) ? S_DN_RDR : S_DN_KR;
        S_DN_RDR: state_q <= S_DN_WTR;
        S_DN_WTR: begin
          if (pkey_q >= mul_key) begin
            pick_q <= CntW'(lc_w + 1'b1);
            pent_q <= mem_rdata;
            pkey_q <= mul_key;
          end
          state_q <= S_DN_KR;
        end
        S_DN_KR: state_q <= S_DN_WR1;
        // write picked child into pos; moving entry descends
        S_DN_WR1: begin
          if (pick_q == pos_q) begin
            // pent_q holds cur here, so the write placed it
            if (next_el < {1'b0, top_q.required}) begin
              cur_q <= '{prio: top_q.prio, elapsed: next_el[31:0],
                         required: top_q.required};
              pos_q <= count_q;
              state_q <= S_INS_WR;
            end else begin
              res_q.finished <= 1'b1;
              state_q <= S_DONE;
            end
          end else begin
            pos_q   <= pick_q;
            state_q <= S_DN_CHK;
          end
        end
        S_DONE: begin
          res_q.switch_total <= sw_q;
          res_q.occupancy    <= 9'(count_q);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE) || done_q;
  assign done_o   = done_q;
  assign result_o = res_q;

  // reinsert never overfills: one slot freed by the extract
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_WR |-> count_q < CntW'(hpd_pkg::Capacity))
    else $error("insert into full heap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(res_q.queue_empty && res_q.queue_full))
    else $error("empty and full flagged together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

endmodule
